// ----- hdl/lfga_pkg.sv -----
// lfga_pkg: shared types, codes and defaults for the lowest free gate allocator
// command and result beat structs, operation codes, sequencer states
// no dependencies
package lfga_pkg;

	localparam int GATES_DEF     = 64;
	localparam int TIME_BITS_DEF = 32;

	localparam int OP_W    = 2;
	localparam int IN_T_W  = 32;
	localparam int TOTAL_W = 7;
	localparam int GATE_W  = 7;
	localparam int COUNT_W = 16;
	localparam int BEST_W  = 17;

	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [BEST_W-1:0]  BEST_MAX  = '1;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic               flight_class;
		logic [IN_T_W-1:0]  start_time;
		logic [IN_T_W-1:0]  end_time;
		logic [TOTAL_W-1:0] total_gates;
	} cmd_t;

	typedef struct packed {
		logic [GATE_W-1:0] assigned_gate;
		logic              status;
		logic [BEST_W-1:0] best_served;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_SUM,
		ST_WALK
	} state_t;

endpackage

// ----- hdl/lfga_ram.sv -----
// lfga_ram: single write port, single registered read port memory
// used for the per-gate end times and use counts
// no dependencies
module lfga_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- hdl/lowest_free_gate_allocator.sv -----
// lowest_free_gate_allocator: two pools of gates, lowest free gate request and best split query
// sequencer with one shared time comparator and two prefix accumulators over lfga_ram memories
// depends on lfga_pkg, lfga_ram
//
// channel   dir  handshake               payload
// command   in   start high, busy low    cmd    (cmd_t)
// result    out  done high, one cycle    result (result_t)
//
// clear and unknown operations: strobe in the cycle after the accepted beat
// request: gate scan (one end time read and compare per cycle), then use count read and write
// query: class-1 prefix sum, then a walk over the splits, one use count read per pool per cycle
// gates in use form a prefix of each pool, tracked by a fill count; no clearing pass after reset
// the result beat cannot be stalled; for requests and queries busy is high from acceptance until the result strobe
module lowest_free_gate_allocator
	import lfga_pkg::*;
#(
	parameter int GATES_PER_CLASS = GATES_DEF,
	parameter int TIME_BITS       = TIME_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int AW  = (GATES_PER_CLASS > 1) ? $clog2(GATES_PER_CLASS) : 1;
	localparam int BD  = 2 * (2 ** AW);
	localparam int FW  = $clog2(GATES_PER_CLASS + 1);
	localparam int CW  = (FW > 8) ? FW : 8;
	localparam int PW  = COUNT_W + FW;
	localparam int SW  = PW + 1;
	localparam logic [FW-1:0] FILL_MAX = FW'(GATES_PER_CLASS);

	state_t state_q, state_d;

	logic [FW-1:0] fill_q [2];
	logic [FW-1:0] fill_d [2];

	logic                 cls_q, cls_d;
	logic [TIME_BITS-1:0] start_q, start_d;
	logic [TIME_BITS-1:0] end_q, end_d;
	logic [CW-1:0]        n_q, n_d;
	logic [CW-1:0]        idx_q, idx_d;
	logic [CW-1:0]        lim_q, lim_d;
	logic [AW-1:0]        gate_q, gate_d;
	logic                 new_q, new_d;
	logic [PW-1:0]        p0_q, p0_d;
	logic [PW-1:0]        p1_q, p1_d;
	logic [SW-1:0]        best_q, best_d;

	logic          v_s1, v_s1_d;
	logic [CW-1:0] gidx_s1, gidx_s1_d;
	logic          m0_s1, m0_s1_d;
	logic          m1_s1, m1_s1_d;
	logic          cmp_s2, cmp_s2_d;

	logic    done_q, done_d;
	result_t result_q, result_d;

	logic                 busy_we;
	logic [AW:0]          busy_waddr, busy_raddr;
	logic [TIME_BITS-1:0] busy_rd;

	logic               use_we0, use_we1;
	logic [AW-1:0]      use_waddr, use0_raddr, use1_raddr;
	logic [COUNT_W-1:0] use_wdata, use0_rd, use1_rd;

	logic [COUNT_W-1:0] cur_cnt;
	logic [AW:0]        gate_num;
	logic [SW-1:0]      sum;
	logic [CW-1:0]      a0, a1;

	lfga_ram #(.DEPTH(BD), .WIDTH(TIME_BITS)) u_busy (
		.clk     (clk),
		.wr_en   (busy_we),
		.wr_addr (busy_waddr),
		.wr_data (end_q),
		.rd_addr (busy_raddr),
		.rd_data (busy_rd)
	);

	lfga_ram #(.DEPTH(GATES_PER_CLASS), .WIDTH(COUNT_W)) u_use0 (
		.clk     (clk),
		.wr_en   (use_we0),
		.wr_addr (use_waddr),
		.wr_data (use_wdata),
		.rd_addr (use0_raddr),
		.rd_data (use0_rd)
	);

	lfga_ram #(.DEPTH(GATES_PER_CLASS), .WIDTH(COUNT_W)) u_use1 (
		.clk     (clk),
		.wr_en   (use_we1),
		.wr_addr (use_waddr),
		.wr_data (use_wdata),
		.rd_addr (use1_raddr),
		.rd_data (use1_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			v_s1      <= 1'b0;
			cmp_s2    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q[0] <= fill_d[0];
			fill_q[1] <= fill_d[1];
			v_s1      <= v_s1_d;
			cmp_s2    <= cmp_s2_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cls_q    <= cls_d;
		start_q  <= start_d;
		end_q    <= end_d;
		n_q      <= n_d;
		idx_q    <= idx_d;
		lim_q    <= lim_d;
		gate_q   <= gate_d;
		new_q    <= new_d;
		p0_q     <= p0_d;
		p1_q     <= p1_d;
		best_q   <= best_d;
		gidx_s1  <= gidx_s1_d;
		m0_s1    <= m0_s1_d;
		m1_s1    <= m1_s1_d;
		result_q <= result_d;
	end

	always_comb begin
		state_d   = state_q;
		fill_d[0] = fill_q[0];
		fill_d[1] = fill_q[1];
		cls_d     = cls_q;
		start_d   = start_q;
		end_d     = end_q;
		n_d       = n_q;
		idx_d     = idx_q;
		lim_d     = lim_q;
		gate_d    = gate_q;
		new_d     = new_q;
		p0_d      = p0_q;
		p1_d      = p1_q;
		best_d    = best_q;
		v_s1_d    = v_s1;
		gidx_s1_d = gidx_s1;
		m0_s1_d   = m0_s1;
		m1_s1_d   = m1_s1;
		cmp_s2_d  = 1'b0;
		done_d    = 1'b0;
		result_d  = result_q;

		busy_we    = 1'b0;
		busy_waddr = {cls_q, gate_q};
		busy_raddr = {cls_q, idx_q[AW-1:0]};
		use_we0    = 1'b0;
		use_we1    = 1'b0;
		use_waddr  = gate_q;
		use_wdata  = '0;
		use0_raddr = gate_q;
		use1_raddr = gate_q;

		cur_cnt  = new_q ? '0 : (cls_q ? use1_rd : use0_rd);
		gate_num = {1'b0, gate_q} + (AW + 1)'(1);
		sum      = SW'(p0_q) + SW'(p1_q);
		a0       = idx_q - CW'(1);
		a1       = n_q - idx_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cls_d    = cmd.flight_class;
					start_d  = TIME_BITS'(cmd.start_time);
					end_d    = TIME_BITS'(cmd.end_time);
					n_d      = CW'(cmd.total_gates);
					idx_d    = '0;
					v_s1_d   = 1'b0;
					p0_d     = '0;
					p1_d     = '0;
					best_d   = '0;
					case (cmd.operation)
						OP_CLEAR: begin
							fill_d[0] = '0;
							fill_d[1] = '0;
							done_d    = 1'b1;
							result_d  = '0;
						end
						OP_REQUEST: begin
							state_d = ST_SCAN;
						end
						OP_QUERY: begin
							lim_d   = (CW'(cmd.total_gates) < CW'(fill_q[1])) ?
								CW'(cmd.total_gates) : CW'(fill_q[1]);
							state_d = ST_SUM;
						end
						default: begin
							done_d   = 1'b1;
							result_d = '0;
						end
					endcase
				end
			end

			ST_SCAN: begin
				if (v_s1 && (busy_rd < start_q)) begin
					// expired gate found
					gate_d  = gidx_s1[AW-1:0];
					new_d   = 1'b0;
					v_s1_d  = 1'b0;
					state_d = ST_CNT_RD;
				end else if (idx_q < CW'(fill_q[cls_q])) begin
					v_s1_d    = 1'b1;
					gidx_s1_d = idx_q;
					idx_d     = idx_q + CW'(1);
				end else if (v_s1) begin
					v_s1_d = 1'b0;
				end else if (fill_q[cls_q] < FILL_MAX) begin
					// first never used gate
					gate_d  = fill_q[cls_q][AW-1:0];
					new_d   = 1'b1;
					state_d = ST_CNT_RD;
				end else begin
					done_d   = 1'b1;
					result_d = '0;
					result_d.status = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			ST_CNT_RD: begin
				state_d = ST_CNT_WR;
			end

			ST_CNT_WR: begin
				use_wdata = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_W'(1);
				use_we0   = !cls_q;
				use_we1   = cls_q;
				busy_we   = 1'b1;
				if (new_q) begin
					fill_d[cls_q] = fill_q[cls_q] + FW'(1);
				end
				done_d   = 1'b1;
				result_d = '0;
				result_d.assigned_gate = GATE_W'(gate_num);
				state_d  = ST_IDLE;
			end

			ST_SUM: begin
				// class-1 uses on gates 1..min(n, class-1 fill count)
				use1_raddr = idx_q[AW-1:0];
				if (v_s1) begin
					p1_d = p1_q + PW'(use1_rd);
				end
				if (idx_q < lim_q) begin
					v_s1_d = 1'b1;
					idx_d  = idx_q + CW'(1);
				end else if (v_s1) begin
					v_s1_d = 1'b0;
				end else begin
					idx_d    = CW'(1);
					cmp_s2_d = 1'b1;
					state_d  = ST_WALK;
				end
			end

			ST_WALK: begin
				use0_raddr = a0[AW-1:0];
				use1_raddr = a1[AW-1:0];
				if (cmp_s2 && (sum > best_q)) begin
					best_d = sum;
				end
				if (v_s1) begin
					p0_d     = p0_q + (m0_s1 ? PW'(use0_rd) : PW'(0));
					p1_d     = p1_q - (m1_s1 ? PW'(use1_rd) : PW'(0));
					cmp_s2_d = 1'b1;
					v_s1_d   = 1'b0;
				end
				if (idx_q <= n_q) begin
					v_s1_d  = 1'b1;
					m0_s1_d = a0 < CW'(fill_q[0]);
					m1_s1_d = a1 < CW'(fill_q[1]);
					idx_d   = idx_q + CW'(1);
				end else if (!v_s1 && !cmp_s2) begin
					done_d   = 1'b1;
					result_d = '0;
					result_d.best_served = (best_q > SW'(BEST_MAX)) ? BEST_MAX : best_q[BEST_W-1:0];
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= FILL_MAX) && (fill_q[1] <= FILL_MAX))
		else $error("fill count beyond pool size");

	a_clear_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.operation == OP_CLEAR)) |=>
		(done && (result == '0) && (fill_q[0] == '0) && (fill_q[1] == '0)))
		else $error("clear beat did not empty pools");

	a_fail_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> ((result.assigned_gate == '0) && (result.best_served == '0)))
		else $error("failed request carries a gate or count");

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for lowest_free_gate_allocator, command beats in, strobed results out
// a scoreboard class predicts gate grants and best split queries; plain tasks drive the block
// depends on lfga_pkg and lowest_free_gate_allocator
`timescale 1ns / 1ps
module tb;
	import lfga_pkg::*;

	localparam int GATES = GATES_DEF;
	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	class gate_scoreboard;
		logic [IN_T_W-1:0]  busy_until [2*GATES];
		bit                 gate_used  [2*GATES];
		logic [COUNT_W-1:0] use_count  [2*GATES];
		result_t            expected_q [$];
		int                 errors;

		function new();
			errors = 0;
			clear_pools();
		endfunction

		function void clear_pools();
			for (int g = 0; g < 2*GATES; g++) begin
				busy_until[g] = '0;
				gate_used[g]  = 1'b0;
				use_count[g]  = '0;
			end
		endfunction

		function int unsigned prefix_uses(int cls, int k);
			int unsigned sum;
			sum = 0;
			if (k > GATES)
				k = GATES;
			for (int g = 0; g < k; g++)
				sum += use_count[cls*GATES + g];
			return sum;
		endfunction

		function void note_beat(cmd_t beat);
			result_t     want;
			int          g;
			int          base;
			int unsigned best;
			int unsigned s;
			want = '0;
			base = beat.flight_class ? GATES : 0;
			case (beat.operation)
			OP_CLEAR: begin
				clear_pools();
			end
			OP_REQUEST: begin
				g = 0;
				while (g < GATES && gate_used[base+g] && !(busy_until[base+g] < beat.start_time))
					g++;
				if (g < GATES) begin
					gate_used[base+g]  = 1'b1;
					busy_until[base+g] = beat.end_time;
					if (use_count[base+g] != COUNT_MAX)
						use_count[base+g]++;
					want.assigned_gate = GATE_W'(g + 1);
					want.status        = STATUS_OK;
				end else begin
					want.status = STATUS_FULL;
				end
			end
			OP_QUERY: begin
				best = 0;
				for (int i = 0; i <= int'(beat.total_gates); i++) begin
					s = prefix_uses(0, i) + prefix_uses(1, int'(beat.total_gates) - i);
					if (s > best)
						best = s;
				end
				if (best > BEST_MAX)
					best = BEST_MAX;
				want.best_served = BEST_W'(best);
			end
			default: ;
			endcase
			expected_q.push_back(want);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: gate %0d status %0d best %0d",
					got.assigned_gate, got.status, got.best_served);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.assigned_gate !== want.assigned_gate) begin
				$error("assigned_gate: expected %0d, actual %0d",
					want.assigned_gate, got.assigned_gate);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.best_served !== want.best_served) begin
				$error("best_served: expected %0d, actual %0d",
					want.best_served, got.best_served);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	gate_scoreboard sb;
	int             burst_left;

	lowest_free_gate_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("lowest_free_gate_allocator: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(result);
	end

	function automatic cmd_t mk(logic [OP_W-1:0] op, logic cls, logic [IN_T_W-1:0] s,
			logic [IN_T_W-1:0] e, logic [TOTAL_W-1:0] n);
		cmd_t beat;
		beat.operation    = op;
		beat.flight_class = cls;
		beat.start_time   = s;
		beat.end_time     = e;
		beat.total_gates  = n;
		return beat;
	endfunction

	task automatic send_beat(input cmd_t beat);
		@(negedge clk);
		start <= 1'b1;
		cmd   <= beat;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_beat(beat);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic issue(input cmd_t beat);
		if (burst_left == 0) begin
			pause_sender($urandom_range(1, 16));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		send_beat(beat);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [IN_T_W-1:0] sched_time [2];
		logic [IN_T_W-1:0] s;
		logic [IN_T_W-1:0] e;
		logic              cls;
		int                long_pct;
		int                counted;
		int                r;
		int                d;

		sb = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		burst_left = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty pools, time extremes, unsigned compare, op 3, clear
		issue(mk(OP_QUERY, 1'b0, '0, '0, 7'd0));
		issue(mk(OP_QUERY, 1'b1, '1, '1, 7'd127));
		issue(mk(OP_UNKNOWN, 1'b1, '1, '1, '1));
		issue(mk(OP_REQUEST, 1'b0, 32'd0, 32'd0, '0));
		issue(mk(OP_REQUEST, 1'b0, 32'd0, 32'hFFFF_FFFF, '0));
		issue(mk(OP_REQUEST, 1'b0, 32'd1, 32'd5, '0));
		issue(mk(OP_REQUEST, 1'b0, 32'd5, 32'd7, '0));
		issue(mk(OP_REQUEST, 1'b0, 32'd6, 32'd6, '0));
		issue(mk(OP_REQUEST, 1'b1, 32'h8000_0000, 32'h8000_0000, '0));
		issue(mk(OP_REQUEST, 1'b1, 32'h7FFF_FFFF, 32'd1, '0));
		issue(mk(OP_REQUEST, 1'b1, 32'h8000_0001, 32'hFFFF_FFFF, '0));
		issue(mk(OP_REQUEST, 1'b1, 32'hFFFF_FFFF, 32'd0, '0));
		issue(mk(OP_QUERY, 1'b0, '0, '0, 7'd1));
		issue(mk(OP_QUERY, 1'b0, '0, '0, 7'd3));
		issue(mk(OP_QUERY, 1'b0, '0, '0, 7'd64));
		issue(mk(OP_QUERY, 1'b0, '0, '0, 7'd100));
		issue(mk(OP_UNKNOWN, 1'b0, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 7'h55));
		issue(mk(OP_QUERY, 1'b1, '0, '0, 7'd5));
		issue(mk(OP_CLEAR, 1'b0, '1, '1, '1));
		issue(mk(OP_QUERY, 1'b0, '0, '0, 7'd127));
		issue(mk(OP_REQUEST, 1'b1, 32'd0, 32'd0, '0));
		drain_results();

		// fill the class-1 pool, then one more request to it finds no free gate
		issue(mk(OP_CLEAR, 1'b0, '0, '0, '0));
		for (int i = 0; i <= GATES; i++)
			issue(mk(OP_REQUEST, 1'b1, 32'(i), 32'hFFFF_FFFF, '0));
		issue(mk(OP_REQUEST, 1'b0, 32'd0, 32'd0, '0));
		issue(mk(OP_QUERY, 1'b0, '0, '0, 7'd64));
		issue(mk(OP_QUERY, 1'b0, '0, '0, 7'd127));
		drain_results();

		// random schedules, ascending starts per class, with noise
		counted  = 0;
		long_pct = 30;
		sched_time[0] = '0;
		sched_time[1] = '0;
		while (counted < 900) begin
			if (counted == 0 || $urandom_range(0, 199) == 0) begin
				issue(mk(OP_CLEAR, 1'($urandom), $urandom, $urandom, 7'($urandom)));
				counted++;
				sched_time[0] = $urandom_range(0, 32'hF000_0000);
				sched_time[1] = $urandom_range(0, 32'hF000_0000);
				case ($urandom_range(0, 2))
				0: long_pct = 3;
				1: long_pct = 30;
				default: long_pct = 70;
				endcase
			end
			if ($urandom_range(0, 149) == 0)
				drain_results();
			r = $urandom_range(0, 99);
			if (r < 70) begin
				cls = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 3) != 0)
					sched_time[cls] += $urandom_range(1, 40);
				s = sched_time[cls];
				d = $urandom_range(0, 99);
				if (d < long_pct)
					e = 32'hFFFF_FFFF - $urandom_range(0, 7);
				else if (d < long_pct + (100 - long_pct) / 2)
					e = s + $urandom_range(0, 30);
				else
					e = s + $urandom_range(0, 600);
				issue(mk(OP_REQUEST, cls, s, e, 7'($urandom)));
				counted++;
			end else if (r < 85) begin
				issue(mk(OP_QUERY, 1'($urandom), $urandom, $urandom,
					($urandom_range(0, 7) == 0) ? 7'($urandom_range(65, 127))
						: 7'($urandom_range(0, 64))));
				counted++;
			end else begin
				d = $urandom_range(0, 19);
				if (d == 0) begin
					issue(mk(OP_CLEAR, 1'($urandom), $urandom, $urandom, 7'($urandom)));
					counted++;
				end else if (d < 4) begin
					issue(mk(OP_UNKNOWN, 1'($urandom), $urandom, $urandom, 7'($urandom)));
				end else if (d < 12) begin
					issue(mk(OP_REQUEST, 1'($urandom), $urandom, $urandom, 7'($urandom)));
					counted++;
				end else begin
					issue(mk(OP_QUERY, 1'($urandom), $urandom, $urandom, 7'($urandom)));
					counted++;
				end
			end
		end

		drain_results();
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("lowest_free_gate_allocator: match");
		else
			$display("lowest_free_gate_allocator: mismatch");
		$finish;
	end

endmodule
